[src/gwm_pkg.sv]
`default_nettype none

package gwm_pkg;

    // pattern geometry
    localparam int PATTERN_MAX = 32;
    localparam int POS_W       = PATTERN_MAX + 1;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int CLOS_LEVELS = $clog2(POS_W);

    // config register file layout
    localparam int NUM_WORDS   = 4;
    localparam int WORD_W      = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int REG_LEN_W   = 6;

    localparam logic [CFG_IDX_W-1:0] REG_CASE_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_CHARS_A = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_CHARS_B = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_CHARS_C = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_CHARS_D = 3'd5;

    localparam logic [7:0] STAR_BYTE  = 8'h2A;
    localparam logic [7:0] QMARK_BYTE = 8'h3F;
    localparam logic [7:0] UPPER_A    = 8'h41;
    localparam logic [7:0] UPPER_Z    = 8'h5A;
    localparam logic [7:0] CASE_DELTA = 8'h20;

    // decoded pattern, one entry per position
    typedef struct packed {
        logic [PATTERN_MAX-1:0]       star;
        logic [PATTERN_MAX-1:0]       qmark;
        logic [PATTERN_MAX-1:0][7:0]  lit_folded;
        logic [PATTERN_MAX-1:0]       pos_en;
        logic [POS_W-1:0]             keep_mask;
        logic [POS_W-1:0]             star_link;
        logic [POS_W-1:0]             end_sel;
        logic                         exact_case;
    } pat_info_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic cs);
        logic [7:0] r;
        r = c;
        if (!cs && (c inside {[UPPER_A:UPPER_Z]}))
        begin
            r = c + CASE_DELTA;
        end
        return r;
    endfunction

    // star closure as a parallel prefix: link[k] lets bit k-1 light bit k
    function automatic logic [POS_W-1:0] star_closure(
        input logic [POS_W-1:0] v,
        input logic [POS_W-1:0] mask,
        input logic [POS_W-1:0] link
    );
        logic [POS_W-1:0] g;
        logic [POS_W-1:0] p;
        logic [POS_W-1:0] g_prev;
        logic [POS_W-1:0] p_prev;
        int d;
        g = v & mask;
        p = link;
        for (int lvl = 0; lvl < CLOS_LEVELS; lvl++)
        begin
            d = 1 << lvl;
            g_prev = g;
            p_prev = p;
            for (int k = 0; k < POS_W; k++)
            begin
                if (k >= d)
                begin
                    g[k] = g_prev[k] | (p_prev[k] & g_prev[k-d]);
                    p[k] = p_prev[k] & p_prev[k-d];
                end
                else
                begin
                    p[k] = 1'b0;
                end
            end
        end
        return g;
    endfunction

endpackage

`default_nettype wire

[src/gwm_ifs.sv]
`default_nettype none

interface gwm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_name;
    logic       no_character;

    modport source (output valid, output text_byte, output end_of_name,
                    output no_character, input ready);
    modport sink   (input valid, input text_byte, input end_of_name,
                    input no_character, output ready);
endinterface

interface gwm_out_if;
    logic valid;
    logic ready;
    logic matched;

    modport source (output valid, output matched, input ready);
    modport sink   (input valid, input matched, output ready);
endinterface

interface gwm_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[src/gwm_cfg_regs.sv]
`default_nettype none

module gwm_cfg_regs
    import gwm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    gwm_cfg_if.sink    cfg,
    output pat_info_t  pat
);

    logic                              exact_case_reg;
    logic [REG_LEN_W-1:0]              pattern_length_reg;
    logic [NUM_WORDS-1:0][WORD_W-1:0]  words_reg;
    logic [NUM_WORDS*WORD_W-1:0]       flat;
    logic [LEN_W-1:0]                  used_len;
    logic                              wr;

    assign cfg.ready = 1'b1;
    assign wr        = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exact_case_reg     <= 1'b1;
            pattern_length_reg <= '0;
            words_reg          <= '0;
        end
        else if (wr)
        begin
            case (cfg.index)
                REG_CASE_MODE:       exact_case_reg <= cfg.data[0];
                REG_PATTERN_LENGTH:  pattern_length_reg <= cfg.data[REG_LEN_W-1:0];
                REG_PATTERN_CHARS_A: words_reg[0] <= cfg.data;
                REG_PATTERN_CHARS_B: words_reg[1] <= cfg.data;
                REG_PATTERN_CHARS_C: words_reg[2] <= cfg.data;
                REG_PATTERN_CHARS_D: words_reg[3] <= cfg.data;
                default: ;
            endcase
        end
    end

    assign flat = words_reg;

    // saturate the length to the supported pattern size
    always_comb
    begin
        if (pattern_length_reg > REG_LEN_W'(PATTERN_MAX))
        begin
            used_len = LEN_W'(PATTERN_MAX);
        end
        else
        begin
            used_len = LEN_W'(pattern_length_reg);
        end
    end

    always_comb
    begin
        pat.exact_case = exact_case_reg;
        pat.star_link  = '0;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            pat.star[i]       = (flat[i*8 +: 8] == STAR_BYTE);
            pat.qmark[i]      = (flat[i*8 +: 8] == QMARK_BYTE);
            pat.lit_folded[i] = fold_byte(flat[i*8 +: 8], exact_case_reg);
            pat.pos_en[i]     = (LEN_W'(i) < used_len);
            pat.star_link[i+1] = pat.star[i] && pat.pos_en[i];
        end
        for (int i = 0; i < POS_W; i++)
        begin
            pat.keep_mask[i] = (LEN_W'(i) <= used_len);
            pat.end_sel[i]   = (LEN_W'(i) == used_len);
        end
    end

endmodule

`default_nettype wire

[src/gwm_nfa_step.sv]
`default_nettype none

module gwm_nfa_step
    import gwm_pkg::*;
(
    input  wire pat_info_t          pat,
    input  wire logic [POS_W-1:0]   live,
    input  wire logic [7:0]         text_byte,
    input  wire logic               no_character,
    output logic      [POS_W-1:0]   live_after,
    output logic                    matched
);

    logic [POS_W-1:0] cur;
    logic [POS_W-1:0] next_raw;
    logic [POS_W-1:0] next_closed;
    logic [7:0]       c_folded;

    assign c_folded = fold_byte(text_byte, pat.exact_case);
    assign cur      = star_closure(live, pat.keep_mask, pat.star_link);

    // one byte of NFA advance, every position in parallel
    always_comb
    begin
        next_raw = '0;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            if (cur[i] && pat.pos_en[i])
            begin
                if (pat.star[i])
                begin
                    next_raw[i] = 1'b1;
                end
                else if (pat.qmark[i] || (pat.lit_folded[i] == c_folded))
                begin
                    next_raw[i+1] = 1'b1;
                end
            end
        end
    end

    assign next_closed = star_closure(next_raw, pat.keep_mask, pat.star_link);
    assign live_after  = no_character ? cur : next_closed;
    assign matched     = |(live_after & pat.end_sel);

endmodule

`default_nettype wire

[src/glob_wildcard_matcher_top.sv]
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+--------------------------------------
//  text_in   | in  | valid / ready | text_byte, end_of_name, no_character
//  result_out| out | valid / ready | matched (one per end_of_name item)
//  cfg       | in  | valid / ready | index, data (ready always high)
//
//  one item per cycle when not stalled; result_out valid follows the text_in
//  transaction (input register, then live-vector update into result register)
//  rst_n clears the live vector to position zero, empties both registers and
//  reloads config defaults
//  a held result stalls text_in only when the next item also ends a name

`default_nettype none

module glob_wildcard_matcher_top
    import gwm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    gwm_in_if.sink     text_in,
    gwm_out_if.source  result_out,
    gwm_cfg_if.sink    cfg
);

    // decoded pattern from the config registers
    pat_info_t pat;

    // input register
    logic             in_valid_reg;
    logic             in_valid_next;
    logic [7:0]       byte_reg;
    logic             eon_reg;
    logic             noch_reg;

    // live pattern positions, star-closed again before each step
    logic [POS_W-1:0] live_reg;
    logic [POS_W-1:0] live_next;
    logic [POS_W-1:0] live_after;

    // result register
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             matched_reg;
    logic             matched_comb;

    logic             in_take;
    logic             stall;
    logic             fire;

    gwm_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .pat   (pat)
    );

    gwm_nfa_step u_step (
        .pat          (pat),
        .live         (live_reg),
        .text_byte    (byte_reg),
        .no_character (noch_reg),
        .live_after   (live_after),
        .matched      (matched_comb)
    );

    // only an end-of-name item needs room in the result register
    assign stall = in_valid_reg && eon_reg && out_valid_reg && !result_out.ready;
    assign fire  = in_valid_reg && !stall;

    assign text_in.ready = !stall;
    assign in_take       = text_in.valid && text_in.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    // restart at position zero after every name
    always_comb
    begin
        live_next = live_reg;
        if (fire)
        begin
            live_next = eon_reg ? POS_W'(1) : live_after;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire && eon_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            live_reg      <= POS_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            live_reg      <= live_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= text_in.text_byte;
            eon_reg  <= text_in.end_of_name;
            noch_reg <= text_in.no_character;
        end
        if (fire && eon_reg)
        begin
            matched_reg <= matched_comb;
        end
    end

    assign result_out.valid   = out_valid_reg;
    assign result_out.matched = matched_reg;

endmodule

`default_nettype wire

[tb/sv/glob_wildcard_matcher_top_tb.sv]
module glob_wildcard_matcher_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gwm_pkg::*;

    // index with no register behind it, writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam int RANDOM_ITEMS = 1050;

    // keeps its own copy of the pattern registers and the live-position vector,
    // predicts the match flag of every finished name and checks the results
    class glob_tracker;
        bit               case_sens;
        logic [5:0]       len_reg;
        logic [63:0]      words [4];
        logic [POS_W-1:0] live;
        logic             expected_matches [$];
        int               errors;
        int               names_checked;

        function new();
            case_sens = 1'b1;
            len_reg = '0;
            foreach (words[i])
            begin
                words[i] = '0;
            end
            live = POS_W'(1);
            errors = 0;
            names_checked = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
            case (idx)
                REG_CASE_MODE:       case_sens = data[0];
                REG_PATTERN_LENGTH:  len_reg = data[5:0];
                REG_PATTERN_CHARS_A: words[0] = data;
                REG_PATTERN_CHARS_B: words[1] = data;
                REG_PATTERN_CHARS_C: words[2] = data;
                REG_PATTERN_CHARS_D: words[3] = data;
                default: ;
            endcase
        endfunction

        function int used_len();
            return (len_reg > PATTERN_MAX) ? PATTERN_MAX : int'(len_reg);
        endfunction

        function logic [7:0] pat_at(int i);
            return words[i / 8][(i % 8) * 8 +: 8];
        endfunction

        function logic [7:0] fold(logic [7:0] c);
            if (!case_sens && c >= UPPER_A && c <= UPPER_Z)
            begin
                return c + CASE_DELTA;
            end
            return c;
        endfunction

        // drop positions past the pattern end, then let each live star light its successor
        function logic [POS_W-1:0] close_stars(logic [POS_W-1:0] v, int len);
            logic [POS_W-1:0] r;
            r = v;
            for (int i = 0; i < POS_W; i++)
            begin
                if (i > len)
                begin
                    r[i] = 1'b0;
                end
            end
            for (int i = 0; i < len; i++)
            begin
                if (r[i] && pat_at(i) == STAR_BYTE)
                begin
                    r[i + 1] = 1'b1;
                end
            end
            return r;
        endfunction

        function void note_text(logic [7:0] b, bit eon, bit noc);
            int               len;
            logic [POS_W-1:0] cur;
            logic [POS_W-1:0] nxt;
            logic [7:0]       p;
            len = used_len();
            cur = close_stars(live, len);
            if (!noc)
            begin
                nxt = '0;
                for (int i = 0; i < len; i++)
                begin
                    if (cur[i])
                    begin
                        p = pat_at(i);
                        if (p == STAR_BYTE)
                        begin
                            nxt[i] = 1'b1;
                        end
                        else if (p == QMARK_BYTE || fold(p) == fold(b))
                        begin
                            nxt[i + 1] = 1'b1;
                        end
                    end
                end
                cur = close_stars(nxt, len);
            end
            if (eon)
            begin
                expected_matches.insert(expected_matches.size(), cur[len]);
                live = POS_W'(1);
            end
            else
            begin
                live = cur;
            end
        endfunction

        function void check_match(logic got);
            logic want;
            if (expected_matches.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("%0t: unexpected result, matched=%b", $realtime, got);
                end
                return;
            end
            want = expected_matches.pop_front();
            names_checked++;
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("%0t: matched mismatch, expected %b, got %b",
                             $realtime, want, got);
                end
            end
        endfunction

        function int pending();
            return expected_matches.size();
        endfunction

        function void close_out();
            if (expected_matches.size() > 0)
            begin
                $display("%0d results never arrived", expected_matches.size());
                errors += expected_matches.size();
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    gwm_in_if  in_bus();
    gwm_out_if res_bus();
    gwm_cfg_if cfg_bus();

    glob_tracker tracker;

    bit          idle_on;      // off gives back-to-back stretches on both sides
    int          hold_cycles;  // long receiver hold-off, counted down by the sink
    int          items_sent;   // random items that the block acts on
    int          phases_run;

    // pattern as last programmed, used to build names that get deep into the pattern
    logic [63:0] pat_words [4];
    logic [5:0]  len_sel;
    bit          cs_sel;

    glob_wildcard_matcher_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_in    (in_bus),
        .result_out (res_bus),
        .cfg        (cfg_bus)
    );

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hard stop, far beyond the slowest legal run
    initial
    begin
        #3_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (!idle_on)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // letters near the folding boundaries and their neighbors
    function automatic logic [7:0] pick_letter();
        case ($urandom_range(0, 7))
            0: return 8'h61;
            1: return UPPER_A;
            2: return 8'h62;
            3: return 8'h42;
            4: return 8'h7A;
            5: return UPPER_Z;
            6: return 8'h40;
            default: return 8'h5B;
        endcase
    endfunction

    function automatic logic [7:0] pick_text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            return pick_letter();
        end
        if (r < 70)
        begin
            return STAR_BYTE;
        end
        if (r < 75)
        begin
            return QMARK_BYTE;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_pattern_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
        begin
            return STAR_BYTE;
        end
        if (r < 45)
        begin
            return QMARK_BYTE;
        end
        if (r < 90)
        begin
            return pick_letter();
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // one text transaction, then a random gap; valid stays high when the gap is zero
    task automatic send_item(logic [7:0] b, bit eon, bit noc);
        int gap;
        in_bus.valid        <= 1'b1;
        in_bus.text_byte    <= b;
        in_bus.end_of_name  <= eon;
        in_bus.no_character <= noc;
        @(posedge clk);
        while (!in_bus.ready)
        begin
            @(posedge clk);
        end
        tracker.note_text(b, eon, noc);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // a whole name from a string; an empty string becomes an empty-name item
    task automatic send_name(string s, bit close);
        if (s.len() == 0)
        begin
            send_item(8'h00, close, 1'b1);
            return;
        end
        for (int i = 0; i < s.len(); i++)
        begin
            send_item(s[i], close && (i == s.len() - 1), 1'b0);
        end
    endtask

    // config transaction; valid is left high so back-to-back writes need no toggle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        @(posedge clk);
        while (!cfg_bus.ready)
        begin
            @(posedge clk);
        end
        tracker.write_reg(idx, data);
    endtask

    task automatic program_all();
        write_reg(REG_CASE_MODE, {63'd0, cs_sel});
        write_reg(REG_PATTERN_LENGTH, {58'd0, len_sel});
        write_reg(REG_PATTERN_CHARS_A, pat_words[0]);
        write_reg(REG_PATTERN_CHARS_B, pat_words[1]);
        write_reg(REG_PATTERN_CHARS_C, pat_words[2]);
        write_reg(REG_PATTERN_CHARS_D, pat_words[3]);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic set_pattern_str(string s, bit cs);
        foreach (pat_words[w])
        begin
            pat_words[w] = '0;
        end
        for (int i = 0; i < s.len(); i++)
        begin
            pat_words[i / 8][(i % 8) * 8 +: 8] = s[i];
        end
        len_sel = 6'(s.len());
        cs_sel = cs;
        program_all();
    endtask

    // stop offering text, wait for all results, then let the pipeline empty
    task automatic settle();
        in_bus.valid <= 1'b0;
        while (tracker.pending() > 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // name built by walking the pattern, sometimes broken, with empty items mixed in
    task automatic send_random_name();
        logic [7:0] name_q [$];
        logic [7:0] p;
        int         len;
        int         r;
        bit         close_empty;
        bit         last;
        len = (len_sel > PATTERN_MAX) ? PATTERN_MAX : int'(len_sel);
        for (int i = 0; i < len; i++)
        begin
            p = pat_words[i / 8][(i % 8) * 8 +: 8];
            if (p == STAR_BYTE)
            begin
                repeat ($urandom_range(0, 3)) name_q.insert(name_q.size(), pick_text_byte());
            end
            else if (p == QMARK_BYTE)
            begin
                name_q.insert(name_q.size(), 8'($urandom_range(0, 255)));
            end
            else if (!cs_sel && $urandom_range(0, 1) &&
                     ((p >= 8'h41 && p <= 8'h5A) || (p >= 8'h61 && p <= 8'h7A)))
            begin
                name_q.insert(name_q.size(), p ^ CASE_DELTA);
            end
            else
            begin
                name_q.insert(name_q.size(), p);
            end
        end
        // break some of the names
        r = $urandom_range(0, 99);
        if (r < 12 && name_q.size() > 0)
        begin
            name_q[$urandom_range(0, name_q.size() - 1)] = 8'($urandom_range(0, 255));
        end
        else if (r < 20)
        begin
            name_q.insert(name_q.size(), pick_text_byte());
        end
        else if (r < 27 && name_q.size() > 0)
        begin
            void'(name_q.pop_back());
        end
        if (name_q.size() == 0)
        begin
            send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
            items_sent++;
            return;
        end
        close_empty = ($urandom_range(0, 6) == 0);
        for (int k = 0; k < name_q.size(); k++)
        begin
            // empty items inside a name change nothing
            if ($urandom_range(0, 9) == 0)
            begin
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
                items_sent++;
            end
            last = (k == name_q.size() - 1) && !close_empty;
            send_item(name_q[k], last, 1'b0);
            items_sent++;
        end
        if (close_empty)
        begin
            send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
            items_sent++;
        end
    endtask

    // result sink: random back-pressure plus one long hold-off on request
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        res_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_bus.valid && res_bus.ready)
            begin
                tracker.check_match(res_bus.matched);
            end
            if (hold_cycles > 0)
            begin
                res_bus.ready <= 1'b0;
                hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                res_bus.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                res_bus.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    initial
    begin : stimulus
        int r;
        int n;
        tracker = new();
        idle_on = 1'b1;
        hold_cycles = 0;
        items_sent = 0;
        phases_run = 0;
        rst_n               <= 1'b0;
        in_bus.valid        <= 1'b0;
        in_bus.text_byte    <= '0;
        in_bus.end_of_name  <= 1'b0;
        in_bus.no_character <= 1'b0;
        cfg_bus.valid       <= 1'b0;
        cfg_bus.index       <= '0;
        cfg_bus.data        <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset pattern is empty: only the empty name matches
        send_name("", 1'b1);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);

        // folded compare, wildcards, an empty item leading a name, a dead name,
        // and a name closed by an empty item
        settle();
        set_pattern_str("a?*b", 1'b0);
        send_name("aqb", 1'b1);
        send_name("AZZZB", 1'b1);
        send_item(8'h55, 1'b0, 1'b1);
        send_name("ab", 1'b1);
        send_name("zzzz", 1'b1);
        send_name("aqb", 1'b0);
        send_item(8'hAA, 1'b1, 1'b1);

        // back to exact compare, plus a write to an index with no register
        settle();
        cs_sel = 1'b1;
        write_reg(REG_CASE_MODE, 64'd1);
        write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_bus.valid <= 1'b0;
        send_name("AQB", 1'b1);
        send_name("aQb", 1'b1);

        // length register beyond the maximum saturates; all stars match anything
        settle();
        foreach (pat_words[w])
        begin
            pat_words[w] = {8{STAR_BYTE}};
        end
        len_sel = 6'd63;
        cs_sel = 1'b0;
        program_all();
        send_name("", 1'b1);
        send_name("?", 1'b1);

        // full-length pattern of all-ones bytes
        settle();
        foreach (pat_words[w])
        begin
            pat_words[w] = '1;
        end
        len_sel = 6'd32;
        cs_sel = 1'b1;
        program_all();
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);

        // pattern changed while a name is half way through
        settle();
        set_pattern_str("ab*", 1'b1);
        send_name("a", 1'b0);
        settle();
        set_pattern_str("a*b", 1'b1);
        send_name("xb", 1'b1);

        // random part, one pattern setting per phase
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            settle();
            r = $urandom_range(0, 9);
            if (r < 2 && phases_run > 0)
            begin
                // rewrite only the case mode, with a random value
                cs_sel = 1'($urandom_range(0, 1));
                write_reg(REG_CASE_MODE, {63'd0, cs_sel});
                cfg_bus.valid <= 1'b0;
            end
            else
            begin
                cs_sel = 1'($urandom_range(0, 1));
                r = $urandom_range(0, 99);
                if (r < 10)
                begin
                    len_sel = 6'd0;
                end
                else if (r < 25)
                begin
                    len_sel = 6'd32;
                end
                else if (r < 32)
                begin
                    len_sel = 6'($urandom_range(33, 63));
                end
                else
                begin
                    len_sel = 6'($urandom_range(1, 10));
                end
                // bytes past the used length stay random
                foreach (pat_words[w])
                begin
                    pat_words[w] = {$urandom, $urandom};
                end
                for (int i = 0; i < PATTERN_MAX && i < len_sel; i++)
                begin
                    pat_words[i / 8][(i % 8) * 8 +: 8] = pick_pattern_byte();
                end
                program_all();
            end
            idle_on = ($urandom_range(0, 3) != 0);
            if (phases_run == 3)
            begin
                // long hold-off on the result side while one-byte names keep coming,
                // so held results back up into the text input
                idle_on = 1'b0;
                hold_cycles = 300;
                repeat (40) send_item(pick_text_byte(), 1'b1, 1'b0);
                items_sent += 40;
                idle_on = 1'b1;
            end
            n = $urandom_range(8, 24);
            repeat (n)
            begin
                if (items_sent < RANDOM_ITEMS)
                begin
                    send_random_name();
                end
            end
            phases_run++;
        end

        // drain, then give the pipeline time to show any stray result
        in_bus.valid <= 1'b0;
        while (tracker.pending() > 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        tracker.close_out();
        $display("covered %0d random items and %0d checked names over %0d random settings",
                 items_sent, tracker.names_checked, phases_run);
        $display("errors counted: %0d", tracker.errors);
        if (tracker.errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
